// ===== rtl/upc_pkg.sv =====
package upc_pkg;

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_F_UP = 8'h46;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_F_LO = 8'h66;
    localparam logic [7:0] CTRL_MAX = 8'h1F;
    localparam logic [7:0] DEL_MIN  = 8'h7F;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // pending escape state of the decoder
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    // one queued item: up to three output bytes, bytes[0] goes out first
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      num;
        logic            last;
    } t_cmd;

    function automatic logic needs_escape(input logic [7:0] c);
        logic r;
        r = 1'b0;
        if (c <= CTRL_MAX || c >= DEL_MIN) begin
            r = 1'b1;
        end else begin
            case (c) inside
                8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2C, 8'h2F,
                8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C,
                8'h5D, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E: r = 1'b1;
                default: r = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_A_UP && c <= CH_F_UP) ||
               (c >= CH_A_LO && c <= CH_F_LO);
    endfunction

    // valid for hex digit characters only
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c <= CH_9) begin
            v = c[3:0];
        end else begin
            v = {1'b0, c[2:0]} + 4'd9;
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = CH_0 + {4'd0, v};
        end else begin
            r = CH_A_UP + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

endpackage

// ===== rtl/upc_front.sv =====
module upc_front
    import upc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_push,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_q_full,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    logic       r_mode;
    logic [1:0] r_cnt;
    logic [7:0] r_pd;
    logic [1:0] n_cnt;
    logic [7:0] n_pd;
    logic [1:0] cnt;
    logic [1:0] k;
    logic       accept;
    t_cmd       cmd;

    assign accept = i_push && !i_q_full;

    always_comb begin
        cmd   = '0;
        n_cnt = r_cnt;
        n_pd  = r_pd;
        k     = 2'd0;
        cnt   = (r_cnt == 2'd3) ? PEND_NONE : r_cnt;
        if (r_mode == MODE_ENCODE) begin
            if (needs_escape(i_in_byte)) begin
                cmd.bytes[0] = CH_PCT;
                cmd.bytes[1] = hex_char(i_in_byte[7:4]);
                cmd.bytes[2] = hex_char(i_in_byte[3:0]);
                cmd.num      = 2'd3;
            end else begin
                cmd.bytes[0] = i_in_byte;
                cmd.num      = 2'd1;
            end
        end else begin
            if (cnt == PEND_DIGIT && is_hex(i_in_byte)) begin
                cmd.bytes[0] = {hex_value(r_pd), hex_value(i_in_byte)};
                cmd.num      = 2'd1;
                n_cnt        = PEND_NONE;
            end else if (cnt == PEND_PCT && is_hex(i_in_byte) && !i_in_last) begin
                n_pd  = i_in_byte;
                n_cnt = PEND_DIGIT;
            end else begin
                // broken escape: flush what is pending verbatim
                case (cnt)
                    PEND_PCT: begin
                        cmd.bytes[0] = CH_PCT;
                        k = 2'd1;
                    end
                    PEND_DIGIT: begin
                        cmd.bytes[0] = CH_PCT;
                        cmd.bytes[1] = r_pd;
                        k = 2'd2;
                    end
                    default: k = 2'd0;
                endcase
                if (i_in_byte == CH_PCT && !i_in_last) begin
                    n_cnt = PEND_PCT;
                end else begin
                    cmd.bytes[k] = i_in_byte;
                    k = k + 2'd1;
                    n_cnt = PEND_NONE;
                end
                cmd.num = k;
            end
            if (i_in_last) begin
                n_cnt = PEND_NONE;
                n_pd  = '0;
            end
        end
        cmd.last = i_in_last;
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = accept && (cmd.num != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
            r_cnt  <= PEND_NONE;
            r_pd   <= '0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
            r_cnt  <= PEND_NONE;
            r_pd   <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_pd  <= n_pd;
        end
    end

endmodule

// ===== rtl/upc_queue.sv =====
module upc_queue
    import upc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/upc_back.sv =====
module upc_back
    import upc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_data,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = i_q_valid && (!r_valid || i_pop);
    assign at_end = (r_idx == i_q_data.num - 2'd1);

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_q_data.bytes[0];
            2'd1:    sel_byte = i_q_data.bytes[1];
            default: sel_byte = i_q_data.bytes[2];
        endcase
    end

    assign o_q_pop = load && at_end;
    assign o_empty = !r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= i_q_data.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/url_percent_codec_top.sv =====
// Path: an item's first output byte is written to the command queue at the edge that
// accepts it and is then loaded into the output register.
// Throughput: one output byte per cycle from the output register while pop is held and
// the queue holds items; an item is popped from the queue when its last byte is loaded.
// Items queue in a QUEUE_DEPTH entry command queue between classifier and emitter.
// Reset (i_rst_n, synchronous, active low): mode encode, nothing pending, all empty.
module url_percent_codec_top
    import upc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic q_full;
    logic cmd_push;
    t_cmd cmd;
    logic q_valid;
    t_cmd q_data;
    logic q_pop;

    assign full = q_full;

    upc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_full   (q_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd)
    );

    upc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_push),
        .i_data  (cmd),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    upc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_byte    (o_out_byte),
        .o_last    (o_out_last)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
    import upc_pkg::*;
();

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       push       = 1'b0;
    logic       pop        = 1'b0;
    logic [7:0] i_in_byte  = 8'h00;
    logic       i_in_last  = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    url_percent_codec_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    t_byte_item src_q[$];
    t_byte_item want_q[$];
    t_byte_item drv_item;
    t_byte_item got_item;

    // predictor state
    logic       cur_mode  = MODE_ENCODE;
    logic [1:0] pend_cnt  = PEND_NONE;
    logic [7:0] pend_char = 8'h00;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_cnt      = 0;
    int stall_cycles  = 0;

    wire in_acc  = push && !full;
    wire out_acc = pop && !empty;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] hex_to_nib(input logic [7:0] c);
        return (c <= "9") ? c[3:0] : c[2:0] + 4'd9;
    endfunction

    function automatic logic [7:0] nib_to_hex(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h37 + {4'd0, v};
    endfunction

    function automatic logic escaped_in_url(input logic [7:0] c);
        if (c <= 8'h1F || c >= 8'h7F) begin
            return 1'b1;
        end
        case (c)
            8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2C, 8'h2F,
            8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C,
            8'h5D, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // expected output bytes for one accepted input byte
    function automatic void codec_predict(input logic [7:0] x, input logic last);
        t_byte_item res[$];
        logic [1:0] cnt;
        if (cur_mode == MODE_ENCODE) begin
            if (escaped_in_url(x)) begin
                res.push_back('{CH_PCT, 1'b0});
                res.push_back('{nib_to_hex(x[7:4]), 1'b0});
                res.push_back('{nib_to_hex(x[3:0]), 1'b0});
            end else begin
                res.push_back('{x, 1'b0});
            end
        end else begin
            cnt = (pend_cnt == PEND_PCT || pend_cnt == PEND_DIGIT) ? pend_cnt : PEND_NONE;
            if (cnt == PEND_DIGIT && is_hex_char(x)) begin
                res.push_back('{{hex_to_nib(pend_char), hex_to_nib(x)}, 1'b0});
                cnt = PEND_NONE;
            end else if (cnt == PEND_PCT && is_hex_char(x) && !last) begin
                pend_char = x;
                cnt = PEND_DIGIT;
            end else begin
                // broken or finished escape: flush what is pending verbatim
                if (cnt != PEND_NONE) begin
                    res.push_back('{CH_PCT, 1'b0});
                end
                if (cnt == PEND_DIGIT) begin
                    res.push_back('{pend_char, 1'b0});
                end
                if (x == CH_PCT && !last) begin
                    cnt = PEND_PCT;
                end else begin
                    res.push_back('{x, 1'b0});
                    cnt = PEND_NONE;
                end
            end
            if (last) begin
                cnt = PEND_NONE;
                pend_char = 8'h00;
            end
            pend_cnt = cnt;
        end
        if (last && res.size() > 0) begin
            res[res.size() - 1].last = 1'b1;
        end
        foreach (res[i]) begin
            want_q.push_back(res[i]);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (in_acc) begin
                codec_predict(i_in_byte, i_in_last);
            end
            if (!(push && full)) begin
                if (src_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = src_q.pop_front();
                    push      <= 1'b1;
                    i_in_byte <= drv_item.data;
                    i_in_last <= drv_item.last;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (out_acc) begin
                if (want_q.size() == 0) begin
                    $error("unexpected item: out_byte %h out_last %b", o_out_byte, o_out_last);
                    fail_cnt++;
                end else begin
                    got_item = want_q.pop_front();
                    if (o_out_byte !== got_item.data) begin
                        $error("out_byte: expected %h, got %h", got_item.data, o_out_byte);
                        fail_cnt++;
                    end
                    if (o_out_last !== got_item.last) begin
                        $error("out_last: expected %b, got %b", got_item.last, o_out_last);
                        fail_cnt++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n || in_acc || out_acc) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("FAIL url_percent_codec_top");
                $finish;
            end
        end
    end

    function automatic void add_item(input logic [7:0] b, input logic l);
        src_q.push_back('{b, l});
    endfunction

    function automatic void add_str(input string s, input logic end_last);
        for (int i = 0; i < s.len(); i++) begin
            add_item(s[i], end_last && (i == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] rand_hex();
        logic [3:0] v;
        v = 4'($urandom_range(15));
        if (v < 4'd10) begin
            return 8'h30 + {4'd0, v};
        end
        return ($urandom_range(1) ? 8'h37 : 8'h57) + {4'd0, v};
    endfunction

    function automatic logic [7:0] rand_nonhex();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (is_hex_char(b));
        return b;
    endfunction

    function automatic void gen_encode(input int n);
        for (int i = 0; i < n; i++) begin
            add_item(8'($urandom_range(255)), ($urandom_range(7) == 0) || (i == n - 1));
        end
    endfunction

    // mostly well-formed escapes, plus broken ones and plain noise
    function automatic void gen_decode(input int n);
        int added;
        int kind;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(9);
            case (kind)
                0, 1, 2, 3, 4: begin
                    add_item(CH_PCT, 1'b0);
                    add_item(rand_hex(), 1'b0);
                    add_item(rand_hex(), 1'b0);
                    added += 3;
                end
                5, 6: begin
                    add_item(8'($urandom_range(255)), 1'b0);
                    added += 1;
                end
                7: begin
                    add_item(CH_PCT, 1'b0);
                    add_item(rand_nonhex(), 1'b0);
                    added += 2;
                end
                8: begin
                    add_item(CH_PCT, 1'b0);
                    add_item(rand_hex(), 1'b0);
                    add_item(rand_nonhex(), 1'b0);
                    added += 3;
                end
                default: begin
                    // string ends inside an escape
                    add_item(CH_PCT, 1'b0);
                    added += 1;
                    if ($urandom_range(1) == 1) begin
                        add_item(rand_hex(), 1'b0);
                        added += 1;
                    end
                    src_q[src_q.size() - 1].last = 1'b1;
                end
            endcase
            if ($urandom_range(5) == 0) begin
                src_q[src_q.size() - 1].last = 1'b1;
            end
        end
        src_q[src_q.size() - 1].last = 1'b1;
    endfunction

    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (src_q.size() != 0 || push || want_q.size() != 0);
        // a lone '%' yields nothing yet, so give the pipeline time to settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_mode  = m;
        pend_cnt  = PEND_NONE;
        pend_char = 8'h00;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 52;

        // encode: range edges and escaped vs copied characters
        write_mode(MODE_ENCODE);
        add_item(8'h00, 1'b0);
        add_item(8'h1F, 1'b0);
        add_item(8'h20, 1'b0);
        add_item(8'h21, 1'b0);
        add_item(CH_PCT, 1'b0);
        add_item(8'h5A, 1'b0);
        add_item(8'h7E, 1'b0);
        add_item(8'h7F, 1'b0);
        add_item(8'h80, 1'b0);
        add_item(8'hFF, 1'b1);
        drain();

        // decode: good escape, broken escapes, '%' breaking an escape
        write_mode(MODE_DECODE);
        add_str("%41", 1'b0);
        add_str("%az", 1'b0);
        add_str("%%4f", 1'b0);
        add_str("%7", 1'b0);
        drain();
        // mode write drops the half escape
        write_mode(MODE_DECODE);
        add_str("%B", 1'b1);
        add_str("%", 1'b1);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_mode(MODE_ENCODE);
            gen_encode(50);
            drain();
            write_mode(MODE_DECODE);
            gen_decode(60);
            drain();
        end

        if (fail_cnt == 0) begin
            $display("PASS url_percent_codec_top");
        end else begin
            $display("FAIL url_percent_codec_top");
        end
        $finish;
    end

endmodule
